### hw/rtl/iommu_pkg.sv
// Shared types, register map and mask constants for the I/O MMU block.
package iommu_pkg;

  localparam int NUM_REGS_DEF = 3072;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_XLATE = 2'd2;
  localparam logic [1:0] OP_PTE   = 2'd3;

  localparam logic [31:0] VERSION_BITS  = 32'h0400_0000;
  localparam logic [31:0] CTRL_KEEP     = 32'h0000_001d;
  localparam logic [31:0] BASE_KEEP     = 32'h07ff_fc00;
  localparam logic [31:0] SLOT_KEEP     = 32'h0001_0003;
  localparam logic [31:0] ARB_KEEP      = 32'h001f_0000;
  localparam logic [31:0] ARB_ID        = 32'h0000_0008;
  localparam logic [31:0] PTE_PAGE_BITS = 32'h07ff_ff00;
  localparam logic [31:0] WIN_16MB      = 32'hff00_0000;

  localparam logic [29:0] IDX_CTRL    = 30'h000;
  localparam logic [29:0] IDX_BASE    = 30'h001;
  localparam logic [29:0] IDX_SLOT_LO = 30'h404;
  localparam logic [29:0] IDX_SLOT_HI = 30'h407;
  localparam logic [29:0] IDX_ARB     = 30'h800;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] address;
    logic [31:0] write_data;
    logic [31:0] pte_word;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [31:0] result_value;
  } out_item_t;

  // Per-item outcome handed from the execute logic to the result stage.
  typedef struct packed {
    logic        use_ram;
    logic [1:0]  kind;
    logic [31:0] value;
  } exec_res_t;

endpackage

### hw/rtl/iommu_ram.sv
// Generic single-write, single-read RAM with registered read data.
module iommu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 3072
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/iommu_exec.sv
// Register decode, write masking, window state and translation arithmetic.
module iommu_exec #(
  parameter int NUM_REGS = iommu_pkg::NUM_REGS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  iommu_pkg::in_item_t         item,
  output logic                        ram_we,
  output logic [$clog2(NUM_REGS)-1:0] ram_waddr,
  output logic [31:0]                 ram_wdata,
  output logic                        ram_re,
  output logic [$clog2(NUM_REGS)-1:0] ram_raddr,
  output iommu_pkg::exec_res_t        res
);

  localparam int AW = $clog2(NUM_REGS);

  logic [31:0] ctrl_r, ctrl_nxt;
  logic [31:0] base_r, base_nxt;
  logic [31:0] win_r, win_nxt;
  logic [31:0] pend_r, pend_nxt;

  logic [29:0] idx;
  logic        in_range;
  logic        is_rd, is_wr, is_xl;
  logic [31:0] wval;
  logic [31:0] masked;
  logic [31:0] ent_addr;
  logic [31:0] phys;

  assign idx      = item.address[31:2];
  assign in_range = idx < 30'(NUM_REGS);
  assign is_rd    = item.opcode == iommu_pkg::OP_READ;
  assign is_wr    = item.opcode == iommu_pkg::OP_WRITE;
  assign is_xl    = item.opcode == iommu_pkg::OP_XLATE;

  // Per-register write mask
  always_comb begin
    if (idx == iommu_pkg::IDX_CTRL) begin
      wval = (item.write_data & iommu_pkg::CTRL_KEEP) | iommu_pkg::VERSION_BITS;
    end else if (idx == iommu_pkg::IDX_BASE) begin
      wval = item.write_data & iommu_pkg::BASE_KEEP;
    end else if (idx inside {[iommu_pkg::IDX_SLOT_LO:iommu_pkg::IDX_SLOT_HI]}) begin
      wval = item.write_data & iommu_pkg::SLOT_KEEP;
    end else if (idx == iommu_pkg::IDX_ARB) begin
      wval = (item.write_data & iommu_pkg::ARB_KEEP) | iommu_pkg::ARB_ID;
    end else begin
      wval = item.write_data;
    end
  end

  assign masked   = item.address & ~win_r;
  assign ent_addr = {base_r[27:0], 4'd0} + {10'd0, masked[31:12], 2'd0};
  assign phys     = {(item.pte_word[27:0] & iommu_pkg::PTE_PAGE_BITS[27:0]), 4'd0}
                  + {20'd0, pend_r[11:0]};

  // Control and base words live in flops so translate sees them directly
  always_comb begin
    ctrl_nxt = ctrl_r;
    base_nxt = base_r;
    win_nxt  = win_r;
    pend_nxt = pend_r;
    if (fire && is_wr && idx == iommu_pkg::IDX_CTRL) begin
      ctrl_nxt = wval;
      win_nxt  = iommu_pkg::WIN_16MB << item.write_data[4:2];
    end
    if (fire && is_wr && idx == iommu_pkg::IDX_BASE) begin
      base_nxt = wval;
    end
    if (fire && is_xl) begin
      pend_nxt = masked;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= iommu_pkg::VERSION_BITS;
      base_r <= '0;
      win_r  <= '0;
      pend_r <= '0;
    end else begin
      ctrl_r <= ctrl_nxt;
      base_r <= base_nxt;
      win_r  <= win_nxt;
      pend_r <= pend_nxt;
    end
  end

  assign ram_we    = fire && is_wr && in_range;
  assign ram_waddr = idx[AW-1:0];
  assign ram_wdata = wval;
  assign ram_raddr = idx[AW-1:0];

  always_comb begin
    res.kind    = item.opcode;
    res.use_ram = 1'b0;
    res.value   = '0;
    case (item.opcode)
      iommu_pkg::OP_READ: begin
        if (idx == iommu_pkg::IDX_CTRL) begin
          res.value = ctrl_r;
        end else if (idx == iommu_pkg::IDX_BASE) begin
          res.value = base_r;
        end else if (in_range) begin
          res.use_ram = 1'b1;
        end
      end
      iommu_pkg::OP_WRITE: res.value = '0;
      iommu_pkg::OP_XLATE: res.value = ent_addr;
      iommu_pkg::OP_PTE:   res.value = phys;
      default:             res.value = '0;
    endcase
  end

  assign ram_re = fire && is_rd && res.use_ram;

endmodule

### hw/rtl/io_mmu_register_file_and_translate.sv
// Top level: I/O MMU register file with page-table address generation.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------
//  in_     | input     | in_valid / in_ready    | in_data  (in_item_t)
//  out_    | output    | out_valid / out_ready  | out_data (out_item_t)
//
// One item per cycle unless the output stalls or clearing runs; each transfer's
// result is registered for the next cycle. The limit is the single read port of
// the register RAM plus one result register. After reset a clearing pass writes
// zero to all NUM_REGS words, one per cycle, and in_ready stays low throughout.
// A stalled output holds the result register and RAM read data; after clearing, a
// new input is taken whenever the result register is empty or draining.
module io_mmu_register_file_and_translate #(
  parameter int NUM_REGS = iommu_pkg::NUM_REGS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  iommu_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output iommu_pkg::out_item_t out_data
);

  localparam int AW = $clog2(NUM_REGS);

  // clearing pass
  logic          clr_busy_r, clr_busy_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;

  // result stage
  logic                 s1_valid_r, s1_valid_nxt;
  iommu_pkg::exec_res_t s1_r, s1_nxt;

  logic                 fire;
  iommu_pkg::exec_res_t res;
  logic                 ex_we, ex_re;
  logic [AW-1:0]        ex_waddr, ex_raddr;
  logic [31:0]          ex_wdata;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [31:0]          ram_wdata;
  logic [31:0]          ram_rdata;

  assign in_ready = !clr_busy_r && (!s1_valid_r || out_ready);
  assign fire     = in_valid && in_ready;

  iommu_exec #(
    .NUM_REGS(NUM_REGS)
  ) u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .item      (in_data),
    .ram_we    (ex_we),
    .ram_waddr (ex_waddr),
    .ram_wdata (ex_wdata),
    .ram_re    (ex_re),
    .ram_raddr (ex_raddr),
    .res       (res)
  );

  // Clearing pass owns the write port until it finishes.
  assign ram_we    = clr_busy_r || ex_we;
  assign ram_waddr = clr_busy_r ? clr_cnt_r : ex_waddr;
  assign ram_wdata = clr_busy_r ? 32'd0 : ex_wdata;

  // Read issues with the transfer, so a read following a write sees it.
  iommu_ram #(
    .WIDTH(32),
    .DEPTH(NUM_REGS)
  ) u_regs (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ex_re),
    .raddr (ex_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_cnt_nxt  = clr_cnt_r;
    if (clr_busy_r) begin
      if (clr_cnt_r == AW'(NUM_REGS - 1)) begin
        clr_busy_nxt = 1'b0;
      end else begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_nxt       = s1_r;
    if (fire) begin
      s1_valid_nxt = 1'b1;
      s1_nxt       = res;
    end else if (out_ready) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
  end

  assign out_valid             = s1_valid_r;
  assign out_data.result_kind  = s1_r.kind;
  assign out_data.result_value = s1_r.use_ram ? ram_rdata : s1_r.value;

endmodule
